// ===== design/mpff_pkg.sv =====
// ---------------------------------------------------------------------------
// mpff_pkg: shared constants of the multi-pool first-fit block allocator
// codes for commands, result status and configuration register indexes
// ---------------------------------------------------------------------------
package mpff_pkg;

  // input field widths
  localparam int unsigned CMD_W    = 1;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned FPOOL_W  = 2;
  localparam int unsigned FBLOCK_W = 8;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned IN_USER_W  = 1;

  // result field widths
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned GPOOL_W  = 2;
  localparam int unsigned GBLOCK_W = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // configuration register widths
  localparam int unsigned EB_W   = 9;
  localparam int unsigned PB_W   = 21;
  localparam int unsigned PIU_W  = 3;
  localparam int unsigned BS_W   = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 21;
  localparam int unsigned NUM_BS = 4;

  // byte need: element_count * element_bytes
  localparam int unsigned BYTES_W = COUNT_W + EB_W;

  localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BYTES    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POOLS_IN_USE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_0  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_2  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE_3  = 3'd6;

  localparam logic [EB_W-1:0]  EB_RESET  = 9'd1;
  localparam logic [PB_W-1:0]  PB_RESET  = 21'd8192;
  localparam logic [PIU_W-1:0] PIU_RESET = 3'd1;
  localparam logic [BS_W-1:0]  BS0_RESET = 17'd32;
  localparam logic [BS_W-1:0]  BS1_RESET = 17'd64;
  localparam logic [BS_W-1:0]  BS2_RESET = 17'd128;
  localparam logic [BS_W-1:0]  BS3_RESET = 17'd256;

endpackage

// ===== design/multi_pool_first_fit_block_allocator_core.sv =====
// ---------------------------------------------------------------------------
// multi_pool_first_fit_block_allocator_core: bitmap first-fit allocator
// up to MAX_POOLS pools share one used-mark ram, scanned one block per cycle
// ---------------------------------------------------------------------------
// allocate: a prep step, then per tried pool a division and a scan of its blocks,
//   then marking of the needed blocks; free: a check, a division and a clear of the
//   span; one result per transaction, one transaction at a time, bounded by the
//   single-bit ram port and the iterative divider
// reset: synchronous active low; registers take their reset values, then the
//   block counts are divided out pool by pool and a clearing pass over every
//   ram address empties the ram; in_tready stays low meanwhile, and the same
//   happens after a pool_bytes or block size write
module multi_pool_first_fit_block_allocator_core #(
  parameter int unsigned MAX_POOLS  = 4,
  parameter int unsigned MAX_BLOCKS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input transaction
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // element_count[15:0], free_pool[17:16], free_block[25:18], zero fill
  input  logic [mpff_pkg::IN_DATA_W-1:0]  in_tdata,
  // cmd[0]
  input  logic [mpff_pkg::IN_USER_W-1:0]  in_tuser,
  // result transaction
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // status[1:0], got_pool[3:2], got_block[11:4], zero fill
  output logic [mpff_pkg::OUT_DATA_W-1:0] out_tdata,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [mpff_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [mpff_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import mpff_pkg::*;

  localparam int unsigned PW    = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int unsigned BW    = $clog2(MAX_BLOCKS);
  localparam int unsigned NBW   = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned NPW   = $clog2(MAX_POOLS + 1);
  localparam int unsigned SELW  = (NPW > FPOOL_W) ? NPW : FPOOL_W;
  localparam int unsigned DEPTH = MAX_POOLS * MAX_BLOCKS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned QW    = BYTES_W + 1;

  // sequencer states
  localparam logic [3:0] S_INIT_DIV  = 4'd0;
  localparam logic [3:0] S_INIT_WAIT = 4'd1;
  localparam logic [3:0] S_CLEAR     = 4'd2;
  localparam logic [3:0] S_IDLE      = 4'd3;
  localparam logic [3:0] S_PREP      = 4'd4;
  localparam logic [3:0] S_A_POOL    = 4'd5;
  localparam logic [3:0] S_A_DIV     = 4'd6;
  localparam logic [3:0] S_A_SCAN    = 4'd7;
  localparam logic [3:0] S_A_MARK    = 4'd8;
  localparam logic [3:0] S_F_CHK     = 4'd9;
  localparam logic [3:0] S_F_DIV     = 4'd10;
  localparam logic [3:0] S_F_CLR     = 4'd11;
  localparam logic [3:0] S_RESP      = 4'd12;

  // configuration registers
  logic [EB_W-1:0]  eb_r, eb_nxt;
  logic [PB_W-1:0]  pb_r, pb_nxt;
  logic [PIU_W-1:0] piu_r, piu_nxt;
  logic [BS_W-1:0]  bs_r [NUM_BS];
  logic [BS_W-1:0]  bs_nxt [NUM_BS];

  // per-pool geometry and free counts
  logic [NBW-1:0] nb_r [MAX_POOLS];
  logic [NBW-1:0] fc_r [MAX_POOLS];
  logic           nb_we, fc_we;
  logic [NBW-1:0] nb_wv, fc_wv;

  logic [3:0]          state_r, state_nxt;
  logic [NPW-1:0]      ip_r, ip_nxt;     // pool under init
  logic [NPW-1:0]      p_r, p_nxt;       // pool being worked on
  logic [AW-1:0]       clr_r, clr_nxt;

  // request fields
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [FPOOL_W-1:0]  fpool_r, fpool_nxt;
  logic [FBLOCK_W-1:0] fblk_r, fblk_nxt;
  logic [BYTES_W-1:0]  bytes_r, bytes_nxt;

  // scan / mark / free sweep
  logic [NBW-1:0] ri_r, ri_nxt;       // next block to read
  logic [BW-1:0]  e_r, e_nxt;         // block whose mark arrives now
  logic           pend_r, pend_nxt;   // a read is in flight
  logic [NBW-1:0] run_r, run_nxt;
  logic [NBW-1:0] start_r, start_nxt;
  logic [NBW-1:0] need_r, need_nxt;
  logic [NBW-1:0] mk_r, mk_nxt;
  logic [NBW-1:0] end_r, end_nxt;

  // pending result and output register
  logic [STATUS_W-1:0] rs_r, rs_nxt;
  logic [GPOOL_W-1:0]  rp_r, rp_nxt;
  logic [GBLOCK_W-1:0] rb_r, rb_nxt;
  logic                ov_r, ov_nxt;
  logic [OUT_DATA_W-1:0] od_r, od_nxt;

  // derived values
  logic [NPW-1:0]  npools;
  logic [SELW-1:0] sel;
  logic [BS_W-1:0] bs_sel;
  logic [NBW-1:0]  nb_sel, fc_sel;

  // divider
  logic               div_start, div_done, div_rnz;
  logic [BYTES_W-1:0] div_a, div_q;
  logic [BS_W-1:0]    div_b;
  logic [QW-1:0]      qplus;

  // ram
  logic          ram_we, ram_wd, ram_rd;
  logic [AW-1:0] ram_wa, ram_ra;

  logic          geo_wr;
  logic [QW+1:0] endw;

  function automatic logic [AW-1:0] addr_of(input logic [SELW-1:0] pl,
                                            input logic [NBW-1:0] blk);
    return AW'(32'(pl) * MAX_BLOCKS + 32'(blk));
  endfunction

  mpff_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ram_ra),
    .rdata (ram_rd)
  );

  mpff_div #(.DW(BYTES_W), .SW(BS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quot     (div_q),
    .rem_nz   (div_rnz)
  );

  // pool count clipped to what the hardware holds
  assign npools = (32'(piu_r) > MAX_POOLS) ? NPW'(MAX_POOLS) : NPW'(piu_r);

  // pool selected for geometry lookups
  always_comb begin
    priority if (state_r == S_INIT_DIV || state_r == S_INIT_WAIT) begin
      sel = SELW'(ip_r);
    end else if (state_r == S_F_CHK) begin
      sel = SELW'(fpool_r);
    end else begin
      sel = SELW'(p_r);
    end
    bs_sel = '0;
    for (int k = 0; k < NUM_BS; k++) begin
      if (32'(sel) == k && k < MAX_POOLS) bs_sel = bs_r[k];
    end
    nb_sel = '0;
    fc_sel = '0;
    for (int k = 0; k < MAX_POOLS; k++) begin
      if (32'(sel) == k) begin
        nb_sel = nb_r[k];
        fc_sel = fc_r[k];
      end
    end
  end

  assign qplus = QW'(div_q) + QW'(div_rnz);
  assign endw  = (QW+2)'(fblk_r) + (QW+2)'(qplus);
  assign geo_wr = cfg_we && (cfg_idx == REG_POOL_BYTES || cfg_idx == REG_BLOCK_SIZE_0 ||
                             cfg_idx == REG_BLOCK_SIZE_1 || cfg_idx == REG_BLOCK_SIZE_2 ||
                             cfg_idx == REG_BLOCK_SIZE_3);

  always_comb begin
    state_nxt = state_r;
    ip_nxt    = ip_r;
    p_nxt     = p_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    cnt_nxt   = cnt_r;
    fpool_nxt = fpool_r;
    fblk_nxt  = fblk_r;
    bytes_nxt = bytes_r;
    ri_nxt    = ri_r;
    e_nxt     = e_r;
    pend_nxt  = 1'b0;
    run_nxt   = run_r;
    start_nxt = start_r;
    need_nxt  = need_r;
    mk_nxt    = mk_r;
    end_nxt   = end_r;
    rs_nxt    = rs_r;
    rp_nxt    = rp_r;
    rb_nxt    = rb_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    eb_nxt    = eb_r;
    pb_nxt    = pb_r;
    piu_nxt   = piu_r;
    bs_nxt    = bs_r;
    nb_we     = 1'b0;
    fc_we     = 1'b0;
    nb_wv     = '0;
    fc_wv     = '0;
    div_start = 1'b0;
    div_a     = bytes_r;
    div_b     = bs_sel;
    ram_we    = 1'b0;
    ram_wa    = addr_of(sel, ri_r);
    ram_wd    = 1'b0;
    ram_ra    = addr_of(sel, ri_r);

    // output register drains independently of the sequencer
    if (ov_r && out_tready) ov_nxt = 1'b0;

    unique case (state_r)
      // divide pool_bytes by each block size to get block counts
      S_INIT_DIV: begin
        if (32'(ip_r) == MAX_POOLS) begin
          clr_nxt   = '0;
          state_nxt = S_CLEAR;
        end else if (bs_sel == '0) begin
          nb_we  = 1'b1;
          fc_we  = 1'b1;
          ip_nxt = ip_r + 1'b1;
        end else begin
          div_start = 1'b1;
          div_a     = BYTES_W'(pb_r);
          state_nxt = S_INIT_WAIT;
        end
      end
      S_INIT_WAIT: begin
        if (div_done) begin
          nb_we     = 1'b1;
          fc_we     = 1'b1;
          nb_wv     = (32'(div_q) > MAX_BLOCKS) ? NBW'(MAX_BLOCKS) : NBW'(div_q);
          fc_wv     = nb_wv;
          ip_nxt    = ip_r + 1'b1;
          state_nxt = S_INIT_DIV;
        end
      end
      // sweep every used mark back to free
      S_CLEAR: begin
        ram_we  = 1'b1;
        ram_wa  = clr_r;
        ram_wd  = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (32'(clr_r) == DEPTH - 1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_nxt   = in_tuser[0];
          cnt_nxt   = in_tdata[COUNT_W-1:0];
          fpool_nxt = in_tdata[COUNT_W +: FPOOL_W];
          fblk_nxt  = in_tdata[COUNT_W+FPOOL_W +: FBLOCK_W];
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        bytes_nxt = BYTES_W'(cnt_r) * BYTES_W'(eb_r);
        p_nxt     = '0;
        rp_nxt    = '0;
        rb_nxt    = '0;
        state_nxt = (cmd_r == CMD_FREE) ? S_F_CHK : S_A_POOL;
      end
      // allocate: try pools in order
      S_A_POOL: begin
        priority if (bytes_r == '0 || p_r >= npools) begin
          rs_nxt    = ST_NO_SPACE;
          state_nxt = S_RESP;
        end else if (nb_sel == '0) begin
          p_nxt = p_r + 1'b1;
        end else begin
          div_start = 1'b1;
          state_nxt = S_A_DIV;
        end
      end
      S_A_DIV: begin
        if (div_done) begin
          if (qplus > QW'(fc_sel)) begin
            p_nxt     = p_r + 1'b1;
            state_nxt = S_A_POOL;
          end else begin
            need_nxt  = NBW'(qplus);
            ri_nxt    = '0;
            run_nxt   = '0;
            start_nxt = '0;
            state_nxt = S_A_SCAN;
          end
        end
      end
      // first-fit scan, one mark per cycle, reads run one ahead
      S_A_SCAN: begin
        if (pend_r) begin
          if (ram_rd) begin
            run_nxt   = '0;
            start_nxt = NBW'(e_r) + 1'b1;
          end else begin
            run_nxt = run_r + 1'b1;
          end
        end
        if (pend_r && !ram_rd && (run_r + 1'b1 == need_r)) begin
          fc_we     = 1'b1;
          fc_wv     = fc_sel - need_r;
          mk_nxt    = '0;
          state_nxt = S_A_MARK;
        end else if (pend_r && (NBW'(e_r) + 1'b1 == nb_sel)) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = S_A_POOL;
        end else if (ri_r < nb_sel) begin
          pend_nxt = 1'b1;
          e_nxt    = BW'(ri_r);
          ri_nxt   = ri_r + 1'b1;
        end
      end
      S_A_MARK: begin
        ram_we = 1'b1;
        ram_wa = addr_of(sel, start_r + mk_r);
        ram_wd = 1'b1;
        mk_nxt = mk_r + 1'b1;
        if (mk_r + 1'b1 == need_r) begin
          rs_nxt    = ST_OK;
          rp_nxt    = GPOOL_W'(p_r);
          rb_nxt    = GBLOCK_W'(start_r);
          state_nxt = S_RESP;
        end
      end
      // free: validate, size the span, clear it
      S_F_CHK: begin
        if (32'(fpool_r) < 32'(npools) && 32'(fblk_r) < 32'(nb_sel)) begin
          p_nxt     = NPW'(fpool_r);
          div_start = 1'b1;
          state_nxt = S_F_DIV;
        end else begin
          rs_nxt    = ST_BAD_FREE;
          state_nxt = S_RESP;
        end
      end
      S_F_DIV: begin
        if (div_done) begin
          end_nxt = (endw > (QW+2)'(nb_sel)) ? nb_sel : NBW'(endw);
          ri_nxt  = NBW'(fblk_r);
          rs_nxt  = ST_OK;
          if (qplus == '0) begin
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_F_CLR;
          end
        end
      end
      // write zero to an address and read its old mark in the same cycle
      S_F_CLR: begin
        if (pend_r && ram_rd) begin
          fc_we = 1'b1;
          fc_wv = fc_sel + 1'b1;
        end
        if (ri_r < end_r) begin
          ram_we   = 1'b1;
          ram_wa   = addr_of(sel, ri_r);
          ram_wd   = 1'b0;
          pend_nxt = 1'b1;
          ri_nxt   = ri_r + 1'b1;
        end else if (!pend_r) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = OUT_DATA_W'({rb_r, rp_r, rs_r});
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // configuration writes; geometry changes restart the init sequence
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_ELEMENT_BYTES: eb_nxt    = cfg_wdata[EB_W-1:0];
        REG_POOL_BYTES:    pb_nxt    = cfg_wdata[PB_W-1:0];
        REG_POOLS_IN_USE:  piu_nxt   = cfg_wdata[PIU_W-1:0];
        REG_BLOCK_SIZE_0:  bs_nxt[0] = cfg_wdata[BS_W-1:0];
        REG_BLOCK_SIZE_1:  bs_nxt[1] = cfg_wdata[BS_W-1:0];
        REG_BLOCK_SIZE_2:  bs_nxt[2] = cfg_wdata[BS_W-1:0];
        REG_BLOCK_SIZE_3:  bs_nxt[3] = cfg_wdata[BS_W-1:0];
        default: ;
      endcase
    end
    if (geo_wr) begin
      ip_nxt    = '0;
      state_nxt = S_INIT_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT_DIV;
      ip_r    <= '0;
      p_r     <= '0;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      ov_r    <= 1'b0;
      eb_r    <= EB_RESET;
      pb_r    <= PB_RESET;
      piu_r   <= PIU_RESET;
      bs_r[0] <= BS0_RESET;
      bs_r[1] <= BS1_RESET;
      bs_r[2] <= BS2_RESET;
      bs_r[3] <= BS3_RESET;
    end else begin
      state_r <= state_nxt;
      ip_r    <= ip_nxt;
      p_r     <= p_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
      eb_r    <= eb_nxt;
      pb_r    <= pb_nxt;
      piu_r   <= piu_nxt;
      bs_r    <= bs_nxt;
    end
    cmd_r   <= cmd_nxt;
    cnt_r   <= cnt_nxt;
    fpool_r <= fpool_nxt;
    fblk_r  <= fblk_nxt;
    bytes_r <= bytes_nxt;
    ri_r    <= ri_nxt;
    e_r     <= e_nxt;
    run_r   <= run_nxt;
    start_r <= start_nxt;
    need_r  <= need_nxt;
    mk_r    <= mk_nxt;
    end_r   <= end_nxt;
    rs_r    <= rs_nxt;
    rp_r    <= rp_nxt;
    rb_r    <= rb_nxt;
    od_r    <= od_nxt;
    for (int k = 0; k < MAX_POOLS; k++) begin
      if (nb_we && 32'(sel) == k) nb_r[k] <= nb_wv;
      if (fc_we && 32'(sel) == k) fc_r[k] <= fc_wv;
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

endmodule

// ===== design/mpff_ram.sv =====
// ---------------------------------------------------------------------------
// mpff_ram: generic simple dual-port ram
// one write port, one read port, registered read returning old data
// ---------------------------------------------------------------------------
module mpff_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/mpff_div.sv =====
// ---------------------------------------------------------------------------
// mpff_div: iterative restoring divider
// one quotient bit per cycle, done pulses when quotient and remainder settle
// ---------------------------------------------------------------------------
module mpff_div #(
  parameter int unsigned DW = 25,
  parameter int unsigned SW = 17
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [SW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic          rem_nz
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] q_r, q_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [SW:0]   rem_sh;
  logic          ge;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, q_r[DW-1]};
    ge       = rem_sh >= {1'b0, dvs_r};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = CW'(DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? SW'(rem_sh - {1'b0, dvs_r}) : SW'(rem_sh);
      q_nxt   = {q_r[DW-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done   = done_r;
  assign quot   = q_r;
  assign rem_nz = rem_r != '0;

endmodule

// ===== design/mpff_chk.sv =====
// ---------------------------------------------------------------------------
// mpff_chk: port-level checks for the allocator core
// watches the stream handshakes and result fields over time
// ---------------------------------------------------------------------------
module mpff_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [mpff_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                            cfg_we,
  input logic [mpff_pkg::CFG_IDX_W-1:0]  cfg_idx
);

  import mpff_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one transaction in flight at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transaction taken while busy");

  // failed results (no space or bad free) carry zero pool and block
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == ST_NO_SPACE || out_tdata[1:0] == ST_BAD_FREE)
      |-> out_tdata[11:2] == '0)
    else $error("failed result with nonzero location");

  // geometry write starts a clearing pass
  a_geo_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_idx == REG_POOL_BYTES || cfg_idx == REG_BLOCK_SIZE_0 ||
               cfg_idx == REG_BLOCK_SIZE_1 || cfg_idx == REG_BLOCK_SIZE_2 ||
               cfg_idx == REG_BLOCK_SIZE_3) |=> !in_tready)
    else $error("input open right after geometry change");

endmodule

bind multi_pool_first_fit_block_allocator_core mpff_chk u_mpff_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_we     (cfg_we),
  .cfg_idx    (cfg_idx)
);

// ===== sim/tb_multi_pool_first_fit_block_allocator_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_multi_pool_first_fit_block_allocator_core: self-checking bench
// drives allocate and free transactions under several pool geometries, keeps
// its own bitmap model of the pools and compares every result transaction
// ---------------------------------------------------------------------------
module tb_multi_pool_first_fit_block_allocator_core;
  import mpff_pkg::*;

  localparam int NPOOL   = 4;
  localparam int NBLK    = 256;
  localparam int WD_LIMIT = 200000;
  localparam int HOLD_CYCLES = 3000;

  // laid out as on out_tdata: status in the lowest bits
  typedef struct packed {
    logic [GBLOCK_W-1:0] block;
    logic [GPOOL_W-1:0]  pool;
    logic [STATUS_W-1:0] status;
  } alloc_res_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [COUNT_W-1:0]  count;
    logic [FPOOL_W-1:0]  fpool;
    logic [FBLOCK_W-1:0] fblock;
    bit                  typed;   // expected result given in the row
    alloc_res_t          res;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  multi_pool_first_fit_block_allocator_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  // shadow of the configuration and of the pool state
  logic [EB_W-1:0]  m_elem_bytes;
  logic [PB_W-1:0]  m_pool_bytes;
  logic [PIU_W-1:0] m_pools;
  logic [BS_W-1:0]  m_bsize [NPOOL];
  bit               m_used  [NPOOL][NBLK];
  int unsigned      m_free  [NPOOL];

  alloc_res_t  expected_q [$];
  int          errors = 0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int          hold_cnt = 0;
  int          stall_left = 0;
  int          quiet_cycles = 0;

  function automatic int unsigned blocks_in_pool(int p);
    int unsigned n;
    if (m_bsize[p] == 0) return 0;
    n = m_pool_bytes / m_bsize[p];
    return (n > NBLK) ? NBLK : n;
  endfunction

  function automatic int unsigned ceil_div(int unsigned a, int unsigned b);
    return a / b + ((a % b) != 0);
  endfunction

  function automatic void clear_pools();
    for (int p = 0; p < NPOOL; p++) begin
      for (int b = 0; b < NBLK; b++) m_used[p][b] = 1'b0;
      m_free[p] = blocks_in_pool(p);
    end
  endfunction

  // works out the result of one request and updates the shadow state
  function automatic alloc_res_t allocate_or_free(req_t r);
    alloc_res_t  res;
    int unsigned bytes, np, nb, need, run, start, span, stop;
    bit          found;
    res = '{status: ST_NO_SPACE, pool: '0, block: '0};
    bytes = r.count * m_elem_bytes;
    np = (m_pools > NPOOL) ? NPOOL : m_pools;
    if (r.cmd == CMD_ALLOC) begin
      if (bytes != 0) begin
        for (int p = 0; p < np; p++) begin
          nb = blocks_in_pool(p);
          if (nb == 0) continue;
          need = ceil_div(bytes, m_bsize[p]);
          if (need > m_free[p]) continue;
          run = 0; start = 0; found = 0;
          for (int i = 0; i < nb; i++) begin
            if (!m_used[p][i]) run++;
            else begin
              run = 0;
              start = i + 1;
            end
            if (run == need) begin
              found = 1;
              break;
            end
          end
          if (!found) continue;
          for (int i = start; i < start + need; i++) m_used[p][i] = 1'b1;
          m_free[p] -= need;
          res = '{status: ST_OK, pool: p[1:0], block: start[7:0]};
          break;
        end
      end
    end else begin
      nb = (r.fpool < np) ? blocks_in_pool(r.fpool) : 0;
      if (r.fblock >= nb) res.status = ST_BAD_FREE;
      else begin
        span = ceil_div(bytes, m_bsize[r.fpool]);
        stop = r.fblock + span;
        if (stop > nb) stop = nb;
        for (int i = r.fblock; i < stop; i++) begin
          if (m_used[r.fpool][i]) begin
            m_used[r.fpool][i] = 1'b0;
            m_free[r.fpool]++;
          end
        end
        res.status = ST_OK;
      end
    end
    return res;
  endfunction

  // valid drops only when the sender actually pauses
  task automatic idle_burst();
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // drives one request, holds it until accepted
  task automatic send_request(req_t r);
    alloc_res_t res;
    idle_burst();
    res = allocate_or_free(r);
    if (r.typed && res != r.res) begin
      $display("%0t directed row disagrees: expected %p predicted %p", $time, r.res, res);
      errors++;
    end
    expected_q = {expected_q, (r.typed ? r.res : res)};
    in_tvalid <= 1'b1;
    in_tuser  <= r.cmd;
    in_tdata  <= {6'd0, r.fblock, r.fpool, r.count};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // waits for all results, then lets the block settle before a write
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ELEMENT_BYTES: m_elem_bytes = val[EB_W-1:0];
      REG_POOL_BYTES: begin
        m_pool_bytes = val[PB_W-1:0];
        clear_pools();
      end
      REG_POOLS_IN_USE: m_pools = val[PIU_W-1:0];
      REG_BLOCK_SIZE_0, REG_BLOCK_SIZE_1, REG_BLOCK_SIZE_2, REG_BLOCK_SIZE_3: begin
        m_bsize[idx - REG_BLOCK_SIZE_0] = val[BS_W-1:0];
        clear_pools();
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic req_t mk(logic c, int unsigned n, int unsigned fp, int unsigned fb);
    req_t r;
    r = '{cmd: c, count: n[15:0], fpool: fp[1:0], fblock: fb[7:0], typed: 0, res: '0};
    return r;
  endfunction

  function automatic req_t mk_exp(logic c, int unsigned n, int unsigned fp,
                                  int unsigned fb, logic [1:0] st, int unsigned gb);
    req_t r;
    r = mk(c, n, fp, fb);
    r.typed = 1;
    r.res = '{status: st, pool: '0, block: gb[7:0]};
    return r;
  endfunction

  // mostly well-formed: allocations of modest size, frees of real spans
  function automatic req_t random_request();
    int unsigned k;
    k = $urandom_range(0, 99);
    if (k < 50) return mk(CMD_ALLOC, $urandom_range(1, 400), 0, 0);
    if (k < 85) return mk(CMD_FREE, $urandom_range(0, 400), $urandom_range(0, 3),
                          $urandom_range(0, 31));
    if (k < 92) return mk(CMD_ALLOC, $urandom_range(0, 65535), 0, 0);
    return mk(1'($urandom_range(0, 1)), $urandom_range(0, 65535), $urandom_range(0, 3),
              $urandom_range(0, 255));
  endfunction

  // result checker
  always @(posedge clk) begin
    alloc_res_t got, want;
    if (out_tvalid && out_tready) begin
      got = out_tdata[11:0];
      if (expected_q.size() == 0) begin
        $display("%0t unexpected result transaction %p", $time, got);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.status != want.status) begin
          $display("%0t status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.pool != want.pool) begin
          $display("%0t got_pool expected %0d actual %0d", $time, want.pool, got.pool);
          errors++;
        end
        if (got.block != want.block) begin
          $display("%0t got_block expected %0d actual %0d", $time, want.block, got.block);
          errors++;
        end
      end
    end
  end

  // receiver: random stall bursts, or one long counted hold-off
  always @(posedge clk) begin
    if (hold_req && hold_cnt < HOLD_CYCLES) begin
      out_tready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      out_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 8));
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we ||
        (!in_tvalid && expected_q.size() == 0))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("tb_multi_pool_first_fit_block_allocator_core NOT OK");
      $finish;
    end
  end

  initial begin
    req_t directed [$];
    m_elem_bytes = EB_RESET;
    m_pool_bytes = PB_RESET;
    m_pools = PIU_RESET;
    m_bsize[0] = BS0_RESET; m_bsize[1] = BS1_RESET;
    m_bsize[2] = BS2_RESET; m_bsize[3] = BS3_RESET;
    clear_pools();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: pool 0 has 256 blocks of 32 bytes
    directed = {
      mk_exp(CMD_ALLOC, 0, 0, 0, ST_NO_SPACE, 0),      // zero size
      mk_exp(CMD_ALLOC, 32, 0, 0, ST_OK, 0),
      mk_exp(CMD_ALLOC, 33, 0, 0, ST_OK, 1),
      mk_exp(CMD_ALLOC, 65535, 0, 0, ST_NO_SPACE, 0),  // too big
      mk_exp(CMD_FREE, 32, 1, 0, ST_BAD_FREE, 0),      // pool not active
      mk_exp(CMD_FREE, 32, 0, 255, ST_OK, 0),          // nothing used
      mk_exp(CMD_FREE, 32, 0, 0, ST_OK, 0),
      mk_exp(CMD_ALLOC, 64, 0, 0, ST_OK, 3),           // hole too small
      mk_exp(CMD_FREE, 0, 0, 1, ST_OK, 0),             // zero span
      mk_exp(CMD_FREE, 65535, 0, 0, ST_OK, 0),         // clipped span
      mk_exp(CMD_ALLOC, 8192, 0, 0, ST_OK, 0),         // whole pool
      mk_exp(CMD_ALLOC, 1, 0, 0, ST_NO_SPACE, 0),      // full
      mk(CMD_FREE, 100, 0, 10),
      mk(CMD_ALLOC, 40, 0, 0)
    };
    foreach (directed[i]) send_request(directed[i]);
    drain();

    // four pools, odd block sizes, zero-block pool and fragmented frees
    write_reg(REG_POOLS_IN_USE, 4);
    write_reg(REG_ELEMENT_BYTES, 256);
    write_reg(REG_BLOCK_SIZE_1, 0);
    write_reg(REG_BLOCK_SIZE_2, 65536);
    directed = {
      mk_exp(CMD_FREE, 1, 1, 0, ST_BAD_FREE, 0),       // zero blocks
      mk_exp(CMD_FREE, 1, 0, 255, ST_OK, 0),
      mk(CMD_ALLOC, 65535, 0, 0),
      mk(CMD_ALLOC, 3000, 0, 0),
      mk(CMD_ALLOC, 1, 0, 0)
    };
    foreach (directed[i]) send_request(directed[i]);

    // long receiver hold-off while requests keep coming
    hold_req = 1'b1;
    repeat (8) send_request(mk(CMD_ALLOC, $urandom_range(0, 3), 0, 0));
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_ELEMENT_BYTES, 1);
          write_reg(REG_POOL_BYTES, 1024);
          write_reg(REG_BLOCK_SIZE_0, 16);
          write_reg(REG_BLOCK_SIZE_1, 8);
          write_reg(REG_BLOCK_SIZE_2, 4);
          write_reg(REG_BLOCK_SIZE_3, 1);
        end
        1: begin
          write_reg(REG_POOL_BYTES, 1048576);
          write_reg(REG_BLOCK_SIZE_0, 1);
          write_reg(REG_BLOCK_SIZE_3, 131071);
          write_reg(REG_ELEMENT_BYTES, 511);
          write_reg(REG_POOLS_IN_USE, 7);
        end
        2: begin
          write_reg(REG_POOL_BYTES, 1);
          write_reg(REG_ELEMENT_BYTES, 0);
        end
        3: begin
          write_reg(REG_POOL_BYTES, 2097151);
          write_reg(REG_ELEMENT_BYTES, 3);
          write_reg(REG_POOLS_IN_USE, 0);
        end
        4: begin
          write_reg(REG_POOLS_IN_USE, 3);
          write_reg(REG_POOL_BYTES, 512);
          write_reg(REG_BLOCK_SIZE_0, 8);
          write_reg(REG_BLOCK_SIZE_1, 2);
          write_reg(REG_BLOCK_SIZE_2, 5);
          write_reg(REG_ELEMENT_BYTES, 1);
        end
        default: idle_on = 1'b0;   // closing stretch without gaps
      endcase
      repeat ((phase == 2 || phase == 3) ? 30 : 113) send_request(random_request());
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0)
      $display("tb_multi_pool_first_fit_block_allocator_core OK");
    else
      $display("tb_multi_pool_first_fit_block_allocator_core NOT OK");
    $finish;
  end

endmodule
